@@ rtl/chdec_pkg.sv @@
// Shared types and constants for the chunked body decoder.
// No dependencies; every other file of the block imports this package.
package chdec_pkg;

  localparam int SIZE_BITS  = 32;
  localparam int LINE_LIMIT = 31;
  localparam int LEN_BITS   = $clog2(LINE_LIMIT + 1);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    K_FRAME = 2'd0,
    K_DATA  = 2'd1,
    K_END   = 2'd2,
    K_ERR   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

endpackage

@@ rtl/chdec_frame.sv @@
// Framing state of the chunked decoder: size-line parse, chunk count, error.
// Depends on chdec_pkg. Produces the result of the byte presented this cycle.
module chdec_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_bit,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output chdec_pkg::result_t res
);
  import chdec_pkg::*;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_DATA = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    HX_WAIT   = 2'd0,
    HX_DIGITS = 2'd1,
    HX_END    = 2'd2
  } hex_state_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    return r;
  endfunction

  logic                 chunked_enable;
  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] remaining_count, remaining_count_next;
  logic [LEN_BITS-1:0]  line_length, line_length_next;
  logic [7:0]           previous_byte, previous_byte_next;
  logic                 starts_with_cr, starts_with_cr_next;
  logic [SIZE_BITS-1:0] hex_accumulator, hex_accumulator_next;
  hex_state_t           hex_state, hex_state_next;

  logic [4:0]          hv;
  logic [LEN_BITS:0]   len_inc;
  logic                fault, ended;

  always_comb begin
    res                  = '{kind: K_FRAME, data: 8'd0};
    phase_next           = phase;
    remaining_count_next = remaining_count;
    line_length_next     = line_length;
    previous_byte_next   = previous_byte;
    starts_with_cr_next  = starts_with_cr;
    hex_accumulator_next = hex_accumulator;
    hex_state_next       = hex_state;
    hv                   = hex_value(in_byte);
    len_inc              = {1'b0, line_length} + 1'b1;
    fault                = 1'b0;
    ended                = 1'b0;

    if (!chunked_enable) begin
      res = '{kind: K_DATA, data: in_byte};
    end else begin
      unique case (phase)
        PH_ERR: begin
          res.kind = K_ERR;
        end
        PH_DONE: begin
          res.kind = K_FRAME;
        end
        PH_DATA: begin
          res = '{kind: K_DATA, data: in_byte};
          remaining_count_next = remaining_count - 1'b1;
          if (remaining_count_next == '0) phase_next = PH_LINE;
        end
        PH_LINE: begin
          if (line_length == '0) starts_with_cr_next = (in_byte == CHAR_CR);
          // The CR LF that trails the previous chunk's data is not parsed.
          if (!(starts_with_cr_next && line_length < LEN_BITS'(2)) &&
              hex_state != HX_END) begin
            if (!hv[4]) begin
              hex_state_next = HX_END;
            end else begin
              hex_state_next = HX_DIGITS;
              if (hex_accumulator != '0 || hv[3:0] != 4'd0) begin
                if (hex_accumulator[SIZE_BITS-1 -: 4] != 4'd0) fault = 1'b1;
                else hex_accumulator_next = {hex_accumulator[SIZE_BITS-5:0], hv[3:0]};
              end
            end
          end
          line_length_next = len_inc[LEN_BITS-1:0];
          if (len_inc >= (LEN_BITS+1)'(LINE_LIMIT)) fault = 1'b1;
          else if (len_inc >= (LEN_BITS+1)'(3) && previous_byte == CHAR_CR &&
                   in_byte == CHAR_LF) ended = 1'b1;
          previous_byte_next = in_byte;

          if (fault) begin
            phase_next = PH_ERR;
            res.kind   = K_ERR;
          end else if (ended) begin
            line_length_next     = '0;
            previous_byte_next   = 8'd0;
            starts_with_cr_next  = 1'b0;
            hex_accumulator_next = '0;
            hex_state_next       = HX_WAIT;
            // The closing LF is never a digit, so the size is already final.
            if (hex_accumulator == '0) begin
              phase_next = PH_DONE;
              res.kind   = K_END;
            end else begin
              remaining_count_next = hex_accumulator;
              phase_next           = PH_DATA;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_enable  <= 1'b0;
      phase           <= PH_LINE;
      remaining_count <= '0;
      line_length     <= '0;
      previous_byte   <= 8'd0;
      starts_with_cr  <= 1'b0;
      hex_accumulator <= '0;
      hex_state       <= HX_WAIT;
    end else begin
      if (cfg_we) chunked_enable <= cfg_bit;
      if (step) begin
        phase           <= phase_next;
        remaining_count <= remaining_count_next;
        line_length     <= line_length_next;
        previous_byte   <= previous_byte_next;
        starts_with_cr  <= starts_with_cr_next;
        hex_accumulator <= hex_accumulator_next;
        hex_state       <= hex_state_next;
      end
    end
  end

endmodule

@@ rtl/chdec_out_reg.sv @@
// Output register of the chunked decoder: holds one result beat until taken.
// Depends on chdec_pkg for the result type.
module chdec_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  chdec_pkg::result_t res,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         kind,
  output logic [7:0]         out_byte
);
  import chdec_pkg::*;

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) held <= res;
  end

  assign kind     = held.kind;
  assign out_byte = held.data;

endmodule

@@ rtl/http_chunked_body_decoder_unit.sv @@
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on chdec_pkg, chdec_frame and chdec_out_reg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_byte) carries one raw body byte per
//   beat. A beat is taken at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid, out_stall, kind, out_byte) returns exactly one
//   result beat for every input beat, in order. kind 0 is a framing byte,
//   1 a payload byte in out_byte, 2 the end of the body, 3 a sticky error.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the single
//   chunked_enable bit; cfg_ready is always high. Write it only while idle.
//
// The result of a byte is loaded into the output register at the edge that
// accepts the byte. Throughput is one byte per cycle while the receiver does
// not stall; the framing state in front of the output register updates once
// per accepted byte. That register lets a new byte in while its beat is being
// taken; when the receiver stalls with a beat held, in_stall rises in the same
// cycle and the held beat stays unchanged until taken.
//
// Synchronous reset drops out_valid, selects pass-through mode and returns
// the framing logic to the start of a chunk-size line.
module http_chunked_body_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte
);
  import chdec_pkg::*;

  result_t res;
  logic    accept;

  assign cfg_ready = 1'b1;
  // Only a held beat that the receiver refuses blocks the input side.
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  chdec_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_bit (cfg_data),
    .step    (accept),
    .in_byte (in_byte),
    .res     (res)
  );

  chdec_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kind      (kind),
    .out_byte  (out_byte)
  );

endmodule

@@ rtl/chdec_checker.sv @@
// Port-level checks for the chunked body decoder, bound to its top level.
// Depends on chdec_pkg for the result codes.
module chdec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] out_byte
);
  import chdec_pkg::*;

  // A held result beat must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte))
    else $error("result beat changed under stall");

  // Every accepted byte produces a result beat in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted byte gave no result beat");

  // Input is blocked only while a result beat is refused.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a refused result");

  // Only payload beats carry a byte.
  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_DATA |-> out_byte == 8'd0)
    else $error("non-payload beat carries data");

endmodule

bind http_chunked_body_decoder_unit chdec_checker u_chdec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .out_byte  (out_byte)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the HTTP/1.1 chunked body decoder unit.
// Depends on chdec_pkg and http_chunked_body_decoder_unit; drives directed and random framed and raw streams.
`timescale 1ns / 1ps

module testbench;
  import chdec_pkg::*;

  // Framing phases and hex parse states of the decoder, as tracked here.
  typedef enum logic [1:0] {
    PH_LINE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_DONE  = 2'd2,
    PH_ERROR = 2'd3
  } frame_phase_t;

  typedef enum logic [1:0] {
    HX_WAIT   = 2'd0,
    HX_DIGITS = 2'd1,
    HX_END    = 2'd2
  } hex_parse_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // The byte stream ends in exactly one sticky state per run, since reset
  // comes only once. The seed picks which one.
  typedef enum int {
    END_ZERO_CHUNK,
    END_LEADING_SPACE,
    END_HEX_PREFIX,
    END_SIGN,
    END_SIZE_OVERFLOW,
    END_LINE_TOO_LONG
  } stream_end_t;

  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_LIMIT   = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;

  http_chunked_body_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .out_byte (out_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the decoder's framing state and of its chunked_enable bit.
  logic                 chunked_mode;
  frame_phase_t         frame_phase;
  logic [SIZE_BITS-1:0] bytes_left;
  logic [LEN_BITS-1:0]  line_len;
  logic [7:0]           last_line_byte;
  logic                 line_has_cr;
  logic [SIZE_BITS-1:0] size_acc;
  hex_parse_t           hex_parse;

  // Body bytes waiting for the driver, and decoded beats waiting for the DUT.
  logic [7:0] body_bytes[$];
  logic [7:0] framed_stream[$];
  result_t    decoded_beats[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          sender_hold = 1'b0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned beats_checked = 0;
  int unsigned fail_count = 0;
  result_t     sent_beat;
  result_t     want_beat;

  function automatic int hex_digit_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  task automatic clear_size_line();
    line_len = '0;
    last_line_byte = 8'h00;
    line_has_cr = 1'b0;
    size_acc = '0;
    hex_parse = HX_WAIT;
  endtask

  // Works out the beat that one accepted body byte must produce, and
  // advances the shadow state exactly as the decoder should.
  task automatic decode_body_byte(input logic [7:0] b, output result_t r);
    int                   pos;
    int                   v;
    bit                   line_done;
    bit                   fault;
    logic [SIZE_BITS-1:0] line_size;
    r.kind = K_FRAME;
    r.data = 8'h00;
    if (!chunked_mode) begin
      r.kind = K_DATA;
      r.data = b;
    end else if (frame_phase == PH_ERROR) begin
      r.kind = K_ERR;
    end else if (frame_phase == PH_DONE) begin
      r.kind = K_FRAME;
    end else if (frame_phase == PH_DATA) begin
      r.kind = K_DATA;
      r.data = b;
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == 0) frame_phase = PH_LINE;
    end else begin
      pos = int'(line_len);
      line_done = 1'b0;
      fault = 1'b0;
      if (pos == 0) line_has_cr = (b == CHAR_CR);
      // The CR LF closing the previous chunk is not part of the size.
      if (!(line_has_cr && pos < 2) && hex_parse != HX_END) begin
        v = hex_digit_value(b);
        if (v < 0) begin
          hex_parse = HX_END;
        end else begin
          hex_parse = HX_DIGITS;
          // Leading zeros are dropped, so only significant digits can overflow.
          if (size_acc != 0 || v != 0) begin
            if (size_acc[SIZE_BITS-1 -: 4] != 0) fault = 1'b1;
            else size_acc = {size_acc[SIZE_BITS-5:0], 4'(v)};
          end
        end
      end
      line_len = LEN_BITS'(pos + 1);
      if (pos + 1 >= LINE_LIMIT) fault = 1'b1;
      else if (pos + 1 >= 3 && last_line_byte == CHAR_CR && b == CHAR_LF) line_done = 1'b1;
      last_line_byte = b;
      if (fault) begin
        frame_phase = PH_ERROR;
        r.kind = K_ERR;
      end else if (line_done) begin
        line_size = size_acc;
        clear_size_line();
        if (line_size == 0) begin
          frame_phase = PH_DONE;
          r.kind = K_END;
        end else begin
          bytes_left = line_size;
          frame_phase = PH_DATA;
        end
      end
    end
  endtask

  initial begin
    chunked_mode = 1'b0;
    frame_phase = PH_LINE;
    bytes_left = '0;
    clear_size_line();
  end

  // Driver: offers the next pending byte when the channel is free, unless the
  // sender is held or a random gap is drawn. A stalled beat keeps its byte and valid.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_body_byte(in_byte, sent_beat);
        decoded_beats.push_back(sent_beat);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (body_bytes.size() != 0 && !sender_hold &&
            $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_byte  <= body_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every taken result beat against the oldest prediction
  // and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (decoded_beats.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("unexpected beat: kind %0d byte %02h", kind, out_byte);
          fail_count++;
        end else begin
          want_beat = decoded_beats.pop_front();
          if (kind !== want_beat.kind || out_byte !== want_beat.data) begin
            if (fail_count < MAX_REPORTS)
              $display("mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
                       want_beat.kind, want_beat.data, kind, out_byte);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 65; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 65; end
      default:   begin send_gap_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  // Called only while idle, right after clk rises.
  task automatic write_chunked_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    chunked_mode = en;
  endtask

  // Waits until every queued byte has come back as a checked beat, or counts a failure once DRAIN_LIMIT runs out.
  task automatic drain();
    int guard;
    guard = 0;
    while (beats_checked < bytes_queued && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (beats_checked < bytes_queued) fail_count++;
    repeat (3) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    body_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic frame_text(input string s);
    for (int i = 0; i < s.len(); i++) framed_stream.push_back(s[i]);
  endtask

  task automatic frame_crlf();
    framed_stream.push_back(CHAR_CR);
    framed_stream.push_back(CHAR_LF);
  endtask

  // Appends one well-formed chunk with random size, optional leading zeros,
  // mixed-case digits, an optional extension and random data.
  task automatic frame_chunk(input bit lead_crlf);
    int         sel;
    int         size;
    int         ndig;
    int         zeros;
    int         ext_len;
    int         line_fixed;
    logic [7:0] c;
    sel = $urandom_range(39);
    if (sel == 0) size = $urandom_range(256, 511);
    else if (sel < 8) size = $urandom_range(17, 80);
    else size = $urandom_range(1, 16);
    ndig = 1;
    while ((size >> (4 * ndig)) != 0) ndig++;
    zeros = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
    ext_len = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
    line_fixed = (lead_crlf ? 2 : 0) + zeros + ndig + 2;
    // Now and then the line is stretched to one byte below the limit.
    if ($urandom_range(24) == 0) ext_len = LINE_LIMIT - 1 - line_fixed;
    if (lead_crlf) frame_crlf();
    repeat (zeros) framed_stream.push_back("0");
    for (int i = ndig - 1; i >= 0; i--)
      framed_stream.push_back(hex_char((size >> (4 * i)) & 15, 1'($urandom_range(1))));
    for (int i = 0; i < ext_len; i++) begin
      if (i == 0) begin
        case ($urandom_range(3))
          0: c = ";";
          1: c = " ";
          2: c = 8'h09;
          default: c = "g";
        endcase
      end else begin
        // Anything but LF, so the line ends only at its own CR LF.
        do c = 8'($urandom_range(255)); while (c == CHAR_LF);
      end
      framed_stream.push_back(c);
    end
    frame_crlf();
    repeat (size) framed_stream.push_back(8'($urandom_range(255)));
  endtask

  // Moves n bytes of the framed stream to the driver, framing more chunks
  // as needed. Leftover bytes carry into the next chunked phase.
  task automatic feed_chunked(input int n);
    for (int i = 0; i < n; i++) begin
      if (framed_stream.size() == 0) frame_chunk($urandom_range(7) != 0);
      queue_byte(framed_stream.pop_front());
    end
  endtask

  task automatic feed_rest();
    while (framed_stream.size() != 0) queue_byte(framed_stream.pop_front());
  endtask

  task automatic feed_raw(input int n);
    repeat (n) queue_byte(8'($urandom_range(255)));
  endtask

  // Ends the body or breaks it, then frames bytes that meet the sticky state.
  task automatic frame_stream_end(input stream_end_t how);
    frame_crlf();
    case (how)
      END_ZERO_CHUNK: begin
        frame_text("0");
        frame_crlf();
        frame_text("X-Trailer: 1");
        frame_crlf();
        frame_crlf();
      end
      END_LEADING_SPACE: begin
        frame_text(" 5");
        frame_crlf();
      end
      END_HEX_PREFIX: begin
        frame_text("0x1A");
        frame_crlf();
      end
      END_SIGN: begin
        frame_text("-3");
        frame_crlf();
      end
      END_SIZE_OVERFLOW: begin
        // Eight significant digits fill the size; the ninth overflows.
        framed_stream.push_back(hex_char($urandom_range(1, 15), 1'b1));
        repeat (8)
          framed_stream.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
        frame_crlf();
      end
      default: begin
        frame_text("1");
        repeat (LINE_LIMIT + 8) framed_stream.push_back(";");
      end
    endcase
    repeat (24) framed_stream.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);
    @(posedge clk);

    // Directed pass-through: byte extremes and framing characters as payload.
    write_chunked_enable(1'b0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    drain();

    // Directed chunked: a first line that opens with a bare CR LF, leading
    // zeros, CR LF inside the data, and a space ending the digit parse.
    write_chunked_enable(1'b1);
    frame_crlf();
    frame_text("00002");
    frame_crlf();
    framed_stream.push_back(CHAR_CR);
    framed_stream.push_back(CHAR_LF);
    frame_crlf();
    frame_text("1 ");
    frame_crlf();
    framed_stream.push_back(8'hFF);
    feed_rest();
    drain();

    // Random phases. Pass-through phases may fall in the middle of a chunk,
    // so the decoder must keep its framing across a mode change.
    for (int p = 0; p < 9; p++) begin
      set_idle(idle_mode_t'(p % 4));
      if (p == 2 || p == 5) begin
        write_chunked_enable(1'b0);
        feed_raw(30);
      end else begin
        write_chunked_enable(1'b1);
        feed_chunked(35);
      end
      if (p == 1) begin
        // Hold the sender until the decoder has returned every beat.
        while (body_bytes.size() > 20) @(posedge clk);
        sender_hold = 1'b1;
        @(posedge clk);
        while (in_valid || beats_checked < bytes_accepted) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end

    // Finish the chunk in flight, then end or break the body.
    set_idle(IDLE_BOTH);
    write_chunked_enable(1'b1);
    feed_rest();
    frame_stream_end(stream_end_t'($urandom_range(5)));
    feed_rest();
    drain();

    // Pass-through still works after the sticky state, which then persists.
    set_idle(IDLE_RECV);
    write_chunked_enable(1'b0);
    feed_raw(12);
    drain();
    set_idle(IDLE_NONE);
    write_chunked_enable(1'b1);
    feed_raw(12);
    drain();

    if (decoded_beats.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/chdec_pkg.sv
rtl/chdec_frame.sv
rtl/chdec_out_reg.sv
rtl/http_chunked_body_decoder_unit.sv
rtl/chdec_checker.sv
tb/testbench.sv
